// File: rtl/core/bfs_shortest_route_core_assert.svh
// Assertion macros shared by the route core checker.
`ifndef BFS_SHORTEST_ROUTE_CORE_ASSERT_SVH
`define BFS_SHORTEST_ROUTE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BSR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define BSR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/bsr_pkg.sv
// Package: constants, types and helpers of the route core.
`timescale 1ns / 1ps
package bsr_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;

  typedef logic [MAX_NODES-1:0] row_t;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_ROUTE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_PATH    = 2'd0,
    STAT_NOROUTE = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_ACK     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_EA_RD, S_EA_WR, S_EB_RD, S_EB_WR,
    S_Q_RD, S_Q_CHK, S_ROW, S_SCAN, S_FOUND,
    S_TR_RD, S_TR_WR, S_EM_RD, S_EM_OUT, S_RESP
  } state_e;

  // index of the lowest set bit, zero when none
  function automatic logic [NODE_W-1:0] lowest_bit(input row_t r);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (r[i]) idx = NODE_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/bsr_ram.sv
// Generic simple dual-port RAM, registered read.
`timescale 1ns / 1ps
module bsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/core/bfs_shortest_route_core.sv
// Top level: shortest route search over a bit adjacency matrix.
`timescale 1ns / 1ps
//
// Channel  | Dir | Transfer when          | Contents
// s_axis   | in  | tvalid & tready        | one command: add edge, clear, route query
// m_axis   | out | tvalid & tready        | one result: path node or status, tlast on final
// cfg      | in  | cfg_valid & cfg_ready  | node_count register (always ready)
//
// Add edge reads and rewrites the rows of both nodes; clear drops the row-valid
// flags. A route query dequeues each node in turn, reads its adjacency row and
// enqueues its new neighbors one at a time, then traces the path back through
// the predecessor memory and emits it from the origin.
// Reset clears the row-valid flags, so the graph is empty at once: no sweep.
// One command at a time; a stalled output holds the engine in place.
module bfs_shortest_route_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [1:0] op, [7:2] node_a, [13:8] node_b, [15:14] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [5:0] path_node, [7:6] status
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i        // node_count
);

  localparam int NW = bsr_pkg::NODE_W;
  localparam int CW = bsr_pkg::CNT_W;
  localparam int MN = bsr_pkg::MAX_NODES;

  bsr_pkg::state_e state_q, state_d;

  logic [6:0]    cfg_q;
  logic [NW-1:0] a_q, a_d, b_q, b_d;
  logic [CW-1:0] head_q, head_d, tail_q, tail_d, n_q, n_d;
  logic [NW-1:0] cur_q, cur_d, v_q, v_d;
  bsr_pkg::row_t cand_q, cand_d, visited_q, visited_d, valid_q, valid_d;
  bsr_pkg::row_t row_vld_q;
  logic          rvld_q;
  logic [1:0]    resp_q, resp_d;

  logic          out_valid_q;
  logic [NW-1:0] out_node_q;
  logic [1:0]    out_status_q;
  logic          out_last_q;

  // output load request
  logic          load;
  logic [NW-1:0] load_node;
  logic [1:0]    load_status;
  logic          load_last;
  logic          slot_free;

  // memory ports
  logic          adj_we;
  logic [NW-1:0] adj_waddr, adj_raddr;
  bsr_pkg::row_t adj_wdata, adj_rdata, adj_row;
  logic          row_set, row_clr;
  logic          pred_we, que_we, stk_we;
  logic [NW-1:0] pred_waddr, pred_wdata, pred_rdata;
  logic [NW-1:0] que_waddr, que_wdata, que_rdata, que_raddr;
  logic [NW-1:0] stk_waddr, stk_wdata, stk_rdata, stk_raddr;

  logic [CW-1:0] count;
  bsr_pkg::row_t valid_mask;
  logic [NW-1:0] pick;
  logic          accept;

  logic [1:0]    in_op;
  logic [NW-1:0] in_a, in_b;

  assign in_op = s_axis_tdata_i[1:0];
  assign in_a  = s_axis_tdata_i[7:2];
  assign in_b  = s_axis_tdata_i[13:8];

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == bsr_pkg::S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_status_q, out_node_q};
  assign m_axis_tlast_o  = out_last_q;

  // effective node count, clamped to the matrix size
  assign count = (cfg_q > 7'(MN)) ? CW'(MN) : CW'(cfg_q);

  always_comb begin
    for (int i = 0; i < MN; i++) valid_mask[i] = (CW'(i) < count);
  end

  // rows never written since reset or clear read as empty
  assign adj_row = rvld_q ? adj_rdata : '0;
  assign pick    = bsr_pkg::lowest_bit(cand_q);

  // stack read always targets the top entry
  assign stk_raddr = n_q[NW-1:0] - NW'(1);
  assign que_raddr = head_q[NW-1:0];

  bsr_ram #(.WIDTH(MN), .DEPTH(MN)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );
  bsr_ram #(.WIDTH(NW), .DEPTH(MN)) u_pred (
    .clk_i, .we_i(pred_we), .waddr_i(pred_waddr), .wdata_i(pred_wdata),
    .raddr_i(v_q), .rdata_o(pred_rdata)
  );
  bsr_ram #(.WIDTH(NW), .DEPTH(MN)) u_que (
    .clk_i, .we_i(que_we), .waddr_i(que_waddr), .wdata_i(que_wdata),
    .raddr_i(que_raddr), .rdata_o(que_rdata)
  );
  bsr_ram #(.WIDTH(NW), .DEPTH(MN)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    head_d    = head_q;
    tail_d    = tail_q;
    n_d       = n_q;
    cur_d     = cur_q;
    v_d       = v_q;
    cand_d    = cand_q;
    visited_d = visited_q;
    valid_d   = valid_q;
    resp_d    = resp_q;

    load        = 1'b0;
    load_node   = '0;
    load_status = bsr_pkg::STAT_ACK;
    load_last   = 1'b1;

    adj_we    = 1'b0;
    adj_waddr = a_q;
    adj_wdata = adj_row;
    adj_raddr = a_q;
    row_set   = 1'b0;
    row_clr   = 1'b0;

    pred_we    = 1'b0;
    pred_waddr = pick;
    pred_wdata = cur_q;
    que_we     = 1'b0;
    que_waddr  = tail_q[NW-1:0];
    que_wdata  = pick;
    stk_we     = 1'b0;
    stk_waddr  = n_q[NW-1:0];
    stk_wdata  = v_q;

    unique case (state_q)
      bsr_pkg::S_IDLE: begin
        if (accept) begin
          a_d = in_a;
          b_d = in_b;
          unique case (bsr_pkg::op_e'(in_op))
            bsr_pkg::OP_ADD: state_d = bsr_pkg::S_EA_RD;
            bsr_pkg::OP_CLEAR: begin
              row_clr = 1'b1;
              resp_d  = bsr_pkg::STAT_ACK;
              state_d = bsr_pkg::S_RESP;
            end
            bsr_pkg::OP_ROUTE: begin
              if (count < CW'(2) || CW'(in_a) >= count || CW'(in_b) >= count) begin
                resp_d  = bsr_pkg::STAT_INVALID;
                state_d = bsr_pkg::S_RESP;
              end else begin
                valid_d   = valid_mask;
                visited_d = bsr_pkg::row_t'(1) << in_a;
                que_we    = 1'b1;
                que_waddr = '0;
                que_wdata = in_a;
                head_d    = '0;
                tail_d    = CW'(1);
                state_d   = bsr_pkg::S_Q_RD;
              end
            end
            bsr_pkg::OP_NONE: state_d = bsr_pkg::S_IDLE;
            default: state_d = bsr_pkg::S_IDLE;
          endcase
        end
      end
      bsr_pkg::S_EA_RD: begin
        adj_raddr = a_q;
        state_d   = bsr_pkg::S_EA_WR;
      end
      bsr_pkg::S_EA_WR: begin
        adj_we    = 1'b1;
        adj_waddr = a_q;
        adj_wdata = adj_row | (bsr_pkg::row_t'(1) << b_q);
        row_set   = 1'b1;
        state_d   = bsr_pkg::S_EB_RD;
      end
      bsr_pkg::S_EB_RD: begin
        adj_raddr = b_q;
        state_d   = bsr_pkg::S_EB_WR;
      end
      bsr_pkg::S_EB_WR: begin
        adj_we    = 1'b1;
        adj_waddr = b_q;
        adj_wdata = adj_row | (bsr_pkg::row_t'(1) << a_q);
        row_set   = 1'b1;
        resp_d    = bsr_pkg::STAT_ACK;
        state_d   = bsr_pkg::S_RESP;
      end
      bsr_pkg::S_Q_RD: begin
        // queue entry at head lands next cycle
        if (head_q < tail_q) state_d = bsr_pkg::S_Q_CHK;
        else                 state_d = bsr_pkg::S_FOUND;
      end
      bsr_pkg::S_Q_CHK: begin
        cur_d     = que_rdata;
        head_d    = head_q + CW'(1);
        adj_raddr = que_rdata;
        if (que_rdata == b_q) state_d = bsr_pkg::S_FOUND;
        else                  state_d = bsr_pkg::S_ROW;
      end
      bsr_pkg::S_ROW: begin
        cand_d  = adj_row & valid_q & ~visited_q;
        state_d = bsr_pkg::S_SCAN;
      end
      bsr_pkg::S_SCAN: begin
        // one new neighbor per cycle, ascending index
        if (cand_q == '0 || tail_q[CW-1]) begin
          state_d = bsr_pkg::S_Q_RD;
        end else begin
          pred_we         = 1'b1;
          que_we          = 1'b1;
          visited_d[pick] = 1'b1;
          cand_d[pick]    = 1'b0;
          tail_d          = tail_q + CW'(1);
        end
      end
      bsr_pkg::S_FOUND: begin
        if (!visited_q[b_q]) begin
          resp_d  = bsr_pkg::STAT_NOROUTE;
          state_d = bsr_pkg::S_RESP;
        end else begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = b_q;
          v_d       = b_q;
          n_d       = CW'(1);
          state_d   = (b_q == a_q) ? bsr_pkg::S_EM_RD : bsr_pkg::S_TR_RD;
        end
      end
      bsr_pkg::S_TR_RD: state_d = bsr_pkg::S_TR_WR;
      bsr_pkg::S_TR_WR: begin
        v_d       = pred_rdata;
        stk_we    = 1'b1;
        stk_waddr = n_q[NW-1:0];
        stk_wdata = pred_rdata;
        n_d       = n_q + CW'(1);
        state_d   = (pred_rdata == a_q || n_q == CW'(MN - 1)) ? bsr_pkg::S_EM_RD
                                                              : bsr_pkg::S_TR_RD;
      end
      bsr_pkg::S_EM_RD: state_d = bsr_pkg::S_EM_OUT;
      bsr_pkg::S_EM_OUT: begin
        if (slot_free) begin
          load        = 1'b1;
          load_node   = stk_rdata;
          load_status = bsr_pkg::STAT_PATH;
          load_last   = (n_q == CW'(1));
          n_d         = n_q - CW'(1);
          state_d     = (n_q == CW'(1)) ? bsr_pkg::S_IDLE : bsr_pkg::S_EM_RD;
        end
      end
      bsr_pkg::S_RESP: begin
        if (slot_free) begin
          load        = 1'b1;
          load_status = resp_q;
          state_d     = bsr_pkg::S_IDLE;
        end
      end
      default: state_d = bsr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsr_pkg::S_IDLE;
      cfg_q       <= 7'(MN);
      row_vld_q   <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      n_q         <= '0;
      visited_q   <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      n_q       <= n_d;
      visited_q <= visited_d;
      if (cfg_valid_i && cfg_ready_o) cfg_q <= cfg_data_i;
      rvld_q <= row_vld_q[adj_raddr];
      if (row_clr)      row_vld_q            <= '0;
      else if (row_set) row_vld_q[adj_waddr] <= 1'b1;
      if (load)                 out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    cur_q   <= cur_d;
    v_q     <= v_d;
    cand_q  <= cand_d;
    valid_q <= valid_d;
    resp_q  <= resp_d;
    if (load) begin
      out_node_q   <= load_node;
      out_status_q <= load_status;
      out_last_q   <= load_last;
    end
  end

endmodule

// File: rtl/core/bsr_checker.sv
// Port-level checker for the route core, bound to the top level.
`timescale 1ns / 1ps
`include "bfs_shortest_route_core_assert.svh"
module bsr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic       cfg_ready_o
);

  // stalled result holds
  `BSR_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
  // a status result is always the only one of its command
  `BSR_ASSERT_NOW(a_status_last, m_axis_tvalid_o && m_axis_tdata_o[7:6] != bsr_pkg::STAT_PATH,
    m_axis_tlast_o)
  // a status result carries no node
  `BSR_ASSERT_NOW(a_status_node, m_axis_tvalid_o && m_axis_tdata_o[7:6] != bsr_pkg::STAT_PATH,
    m_axis_tdata_o[5:0] == 6'd0)
  // register port never stalls
  `BSR_ASSERT_NOW(a_cfg_ready, rst_ni, cfg_ready_o)

endmodule

bind bfs_shortest_route_core bsr_checker u_bsr_checker (
  .clk_i, .rst_ni, .m_axis_tvalid_o, .m_axis_tready_i,
  .m_axis_tdata_o, .m_axis_tlast_o, .cfg_ready_o
);

// File: test/bfs_shortest_route_core_test.sv
// Testbench for the shortest route core: directed and random commands, checked against a predictor.
`timescale 1ns / 1ps

module bfs_shortest_route_core_test;

  // one result of the route core
  typedef struct {
    logic [5:0]       path_node;
    bsr_pkg::status_e status;
    logic             last;
  } route_result_t;

  // Predicts results from accepted commands and checks the result stream.
  class route_scoreboard;
    logic [63:0]   adj_rows [64];
    logic [6:0]    node_count;
    route_result_t pending_q [$];
    int            errors;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      node_count = 7'd64;
      errors = 0;
    endfunction

    function void push(logic [5:0] node, bsr_pkg::status_e st, logic lst);
      route_result_t r;
      r.path_node = node;
      r.status = st;
      r.last = lst;
      pending_q.push_back(r);
    endfunction

    // breadth-first search; neighbors taken in ascending index order
    function void search(int org, int dst);
      int          count;
      logic [63:0] valid_mask, seen, row;
      int          queue [64];
      int          pred [64];
      int          trail [64];
      int          head, tail, cur, n, v;
      count = (node_count > 64) ? 64 : int'(node_count);
      if (count < 2 || org >= count || dst >= count) begin
        push('0, bsr_pkg::STAT_INVALID, 1'b1);
        return;
      end
      valid_mask = (count >= 64) ? '1 : ((64'd1 << count) - 64'd1);
      seen = 64'd1 << org;
      queue[0] = org;
      head = 0;
      tail = 1;
      while (head < tail && head < 64) begin
        cur = queue[head];
        head++;
        if (cur == dst) break;
        row = adj_rows[cur] & valid_mask & ~seen;
        for (int k = 0; k < count; k++) begin
          if (row[k] && tail < 64) begin
            seen[k] = 1'b1;
            pred[k] = cur;
            queue[tail] = k;
            tail++;
          end
        end
      end
      if (!seen[dst]) begin
        push('0, bsr_pkg::STAT_NOROUTE, 1'b1);
        return;
      end
      n = 0;
      v = dst;
      trail[n] = v;
      n++;
      while (v != org && n < 64) begin
        v = pred[v];
        trail[n] = v;
        n++;
      end
      for (int i = 0; i < n; i++)
        push(6'(trail[n-1-i]), bsr_pkg::STAT_PATH, (i + 1 == n));
    endfunction

    // accepted command transfer
    function void note_command(logic [15:0] data);
      bsr_pkg::op_e op;
      logic [5:0]   a, b;
      op = bsr_pkg::op_e'(data[1:0]);
      a = data[7:2];
      b = data[13:8];
      case (op)
        bsr_pkg::OP_ADD: begin
          adj_rows[a][b] = 1'b1;
          adj_rows[b][a] = 1'b1;
          push('0, bsr_pkg::STAT_ACK, 1'b1);
        end
        bsr_pkg::OP_CLEAR: begin
          foreach (adj_rows[i]) adj_rows[i] = '0;
          push('0, bsr_pkg::STAT_ACK, 1'b1);
        end
        bsr_pkg::OP_ROUTE: search(int'(a), int'(b));
        default: ;
      endcase
    endfunction

    // accepted result transfer
    function void check_result(logic [7:0] data, logic lst);
      route_result_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result: path_node %0d status %0d last %0d",
               data[5:0], data[7:6], lst);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (data[5:0] !== exp_r.path_node) begin
        $error("path_node: expected %0d, got %0d", exp_r.path_node, data[5:0]);
        errors++;
      end
      if (data[7:6] !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, data[7:6]);
        errors++;
      end
      if (lst !== exp_r.last) begin
        $error("last: expected %0d, got %0d", exp_r.last, lst);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 600;
  localparam int CYCLE_LIMIT   = 3_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;

  route_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycles = 0;
  int cur_count = 64;

  bfs_shortest_route_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // monitor both streams; receiver back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) sb.note_command(s_axis_tdata_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
    m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // present one command; valid stays high on return unless an idle gap drops it
  task automatic send_cmd(bsr_pkg::op_e op, int a, int b);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {2'b00, 6'(b), 6'(a), op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // one edge first so the last accepted command is noted before counting
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // register write only while idle
  task automatic write_count(int value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= 7'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.node_count = 7'(value);
    cur_count = value;
  endtask

  // mostly in-range nodes, some anywhere in the field
  function automatic int pick_node();
    if ($urandom_range(99) < 88) return $urandom_range(cur_count - 1);
    return $urandom_range(63);
  endfunction

  task automatic random_phase(int items);
    int done, r;
    done = 0;
    send_cmd(bsr_pkg::OP_CLEAR, 0, 0);
    while (done < items) begin
      r = $urandom_range(99);
      if (done == items / 2) begin
        drain();  // hold off until the core has answered everything
      end
      if (r < 48) send_cmd(bsr_pkg::OP_ADD, pick_node(), pick_node());
      else if (r < 51) send_cmd(bsr_pkg::OP_CLEAR, pick_node(), pick_node());
      else if (r < 96) send_cmd(bsr_pkg::OP_ROUTE, pick_node(), pick_node());
      else begin
        send_cmd(bsr_pkg::OP_NONE, $urandom_range(63), $urandom_range(63));
        continue;
      end
      done++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every op, self loop, single-node route, no route
    send_cmd(bsr_pkg::OP_ADD, 0, 63);
    send_cmd(bsr_pkg::OP_ADD, 63, 0);
    send_cmd(bsr_pkg::OP_ADD, 5, 5);
    send_cmd(bsr_pkg::OP_ROUTE, 0, 63);
    send_cmd(bsr_pkg::OP_ROUTE, 63, 63);
    send_cmd(bsr_pkg::OP_ROUTE, 5, 6);
    send_cmd(bsr_pkg::OP_ADD, 1, 2);
    send_cmd(bsr_pkg::OP_ADD, 2, 3);
    send_cmd(bsr_pkg::OP_ADD, 3, 42);
    send_cmd(bsr_pkg::OP_ROUTE, 1, 42);
    send_cmd(bsr_pkg::OP_ROUTE, 42, 1);
    send_cmd(bsr_pkg::OP_NONE, 63, 63);
    send_cmd(bsr_pkg::OP_CLEAR, 0, 0);
    send_cmd(bsr_pkg::OP_ROUTE, 0, 63);
    write_count(1);
    send_cmd(bsr_pkg::OP_ROUTE, 0, 0);
    send_cmd(bsr_pkg::OP_ADD, 0, 1);
    write_count(2);
    send_cmd(bsr_pkg::OP_ROUTE, 1, 0);
    send_cmd(bsr_pkg::OP_ROUTE, 0, 2);
    send_cmd(bsr_pkg::OP_ADD, 1, 9);  // edge beyond node_count is stored but not followed
    send_cmd(bsr_pkg::OP_ROUTE, 0, 1);
    write_count(10);
    send_cmd(bsr_pkg::OP_ROUTE, 0, 9);

    tx_idle_pct = 7;
    rx_idle_pct = 85;
    random_phase(35);
    write_count(64);
    tx_idle_pct = 85;
    rx_idle_pct = 7;
    random_phase(35);
    write_count($urandom_range(24, 3));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(35);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
